/* rtl/ctc_pkg.sv */
`default_nettype none
package ctc_pkg;

  localparam int TGT_W  = 256;
  localparam int CODE_W = 32;
  localparam int MANT_W = 24;
  localparam int WORD_W = 64;

  typedef enum logic {
    CMD_EXPAND   = 1'b0,
    CMD_COMPRESS = 1'b1
  } ctc_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SIGN    = 2'd1,
    ST_EXP_OOR = 2'd2
  } ctc_status_t;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    ctc_status_t      status;
  } ctc_exp_res_t;

endpackage
`default_nettype wire

/* rtl/compact_target_codec_unit.sv */
`default_nettype none
// Compact target codec: converts a 32-bit compact code (exponent byte, sign
// bit, 23-bit mantissa) to a 256-bit target, or a 256-bit target back to
// its compact code.
// Input: a transaction is taken on a rising edge with start high and busy
// low. busy is always low, so one transaction may be issued every cycle.
// in_command selects expand (0) or compress (1).
// Output: out_strobe is high for one cycle with the result on the out_
// ports, once the transaction has passed the input register and the
// result register. The receiver cannot stall;
// each result must be taken in the cycle it is shown.
// Throughput: one transaction per cycle; the conversion logic sits between
// the input register and the result register.
// Configuration: cfg_we/cfg_wdata write the code returned for an all-zero
// target; write it only when no transaction is in flight.
// Reset (rst_n low, synchronous): clears the pipeline valids and the
// zero-target code; no results come out of reset.
module compact_target_codec_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_command,
  input  wire logic [ctc_pkg::CODE_W-1:0] in_compact_in,
  input  wire logic [ctc_pkg::WORD_W-1:0] in_target_in_w3,
  input  wire logic [ctc_pkg::WORD_W-1:0] in_target_in_w2,
  input  wire logic [ctc_pkg::WORD_W-1:0] in_target_in_w1,
  input  wire logic [ctc_pkg::WORD_W-1:0] in_target_in_w0,
  output logic                            out_strobe,
  output logic      [ctc_pkg::WORD_W-1:0] out_target_out_w3,
  output logic      [ctc_pkg::WORD_W-1:0] out_target_out_w2,
  output logic      [ctc_pkg::WORD_W-1:0] out_target_out_w1,
  output logic      [ctc_pkg::WORD_W-1:0] out_target_out_w0,
  output logic      [ctc_pkg::CODE_W-1:0] out_compact_out,
  output logic      [1:0]                 out_status,
  input  wire logic                       cfg_we,
  input  wire logic [ctc_pkg::CODE_W-1:0] cfg_wdata
);
  import ctc_pkg::*;

  logic               in_vld_r;
  ctc_cmd_t           cmd_r;
  logic [CODE_W-1:0]  code_r;
  logic [TGT_W-1:0]   tgt_r;
  logic [CODE_W-1:0]  zero_code_r;

  logic               res_vld_r;
  logic [TGT_W-1:0]   res_tgt_r;
  logic [TGT_W-1:0]   res_tgt_nxt;
  logic [CODE_W-1:0]  res_code_r;
  logic [CODE_W-1:0]  res_code_nxt;
  ctc_status_t        res_st_r;
  ctc_status_t        res_st_nxt;

  ctc_exp_res_t       exp_res;
  logic [CODE_W-1:0]  cmp_code;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      res_vld_r   <= 1'b0;
      zero_code_r <= '0;
    end else begin
      in_vld_r  <= accept;
      res_vld_r <= in_vld_r;
      if (cfg_we) begin
        zero_code_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= ctc_cmd_t'(in_command);
      code_r <= in_compact_in;
      tgt_r  <= {in_target_in_w3, in_target_in_w2, in_target_in_w1, in_target_in_w0};
    end
    if (in_vld_r) begin
      res_tgt_r  <= res_tgt_nxt;
      res_code_r <= res_code_nxt;
      res_st_r   <= res_st_nxt;
    end
  end

  ctc_expand u_expand (
    .code (code_r),
    .res  (exp_res)
  );

  ctc_compress u_compress (
    .target    (tgt_r),
    .zero_code (zero_code_r),
    .code      (cmp_code)
  );

  always_comb begin
    case (cmd_r)
      CMD_EXPAND: begin
        res_tgt_nxt  = exp_res.target;
        res_code_nxt = '0;
        res_st_nxt   = exp_res.status;
      end
      CMD_COMPRESS: begin
        res_tgt_nxt  = '0;
        res_code_nxt = cmp_code;
        res_st_nxt   = ST_OK;
      end
      default: begin
        res_tgt_nxt  = '0;
        res_code_nxt = '0;
        res_st_nxt   = ST_OK;
      end
    endcase
  end

  assign out_strobe        = res_vld_r;
  assign out_target_out_w3 = res_tgt_r[4*WORD_W-1:3*WORD_W];
  assign out_target_out_w2 = res_tgt_r[3*WORD_W-1:2*WORD_W];
  assign out_target_out_w1 = res_tgt_r[2*WORD_W-1:WORD_W];
  assign out_target_out_w0 = res_tgt_r[WORD_W-1:0];
  assign out_compact_out   = res_code_r;
  assign out_status        = res_st_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("result missing two cycles after accept");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result without a transaction");

  a_compress_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_compact_out != '0) |-> (out_status == ST_OK))
    else $error("compress result carries nonzero status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status != 2'd3))
    else $error("undefined status code");

endmodule
`default_nettype wire

/* rtl/ctc_expand.sv */
`default_nettype none
module ctc_expand (
  input  wire logic [ctc_pkg::CODE_W-1:0] code,
  output ctc_pkg::ctc_exp_res_t           res
);
  import ctc_pkg::*;

  localparam int WIDE_W = TGT_W + MANT_W;

  logic              dec;
  logic [MANT_W-1:0] mant;
  logic [8:0]        e_adj;
  logic              e_neg;
  logic              in_range;
  logic [WIDE_W-1:0] wide;

  always_comb begin
    dec      = (code[22:16] == 7'd0);
    mant     = dec ? {code[15:0], 8'd0} : {1'b0, code[22:0]};
    e_neg    = dec && (code[31:24] == 8'd0);
    e_adj    = {1'b0, code[31:24]} - {8'd0, dec};
    in_range = !e_neg && (e_adj <= 9'd34);
    wide     = {{TGT_W{1'b0}}, mant} << {e_adj[5:0], 3'b000};
    res.target = in_range ? wide[WIDE_W-1:MANT_W] : '0;
    if (code[23]) begin
      res.status = ST_SIGN;
    end else if (e_neg || (e_adj > 9'd32)) begin
      res.status = ST_EXP_OOR;
    end else begin
      res.status = ST_OK;
    end
  end

endmodule
`default_nettype wire

/* rtl/ctc_compress.sv */
`default_nettype none
module ctc_compress (
  input  wire logic [ctc_pkg::TGT_W-1:0]  target,
  input  wire logic [ctc_pkg::CODE_W-1:0] zero_code,
  output logic      [ctc_pkg::CODE_W-1:0] code
);
  import ctc_pkg::*;

  localparam int NBYTES = TGT_W / 8;
  localparam int EXT_W  = TGT_W + MANT_W;

  logic [4:0]        top;
  logic              any;
  logic [EXT_W-1:0]  ext;
  logic [8:0]        base;
  logic [MANT_W-1:0] mant;
  logic [MANT_W-1:0] mant_n;
  logic [7:0]        expo;

  // highest nonzero byte
  always_comb begin
    top = '0;
    any = 1'b0;
    for (int i = 0; i < NBYTES; i++) begin
      if (target[8*i +: 8] != 8'd0) begin
        top = 5'(i);
        any = 1'b1;
      end
    end
  end

  always_comb begin
    ext    = {target, {MANT_W{1'b0}}};
    base   = {1'b0, top, 3'b000} + 9'd8;
    mant   = ext[base +: MANT_W];
    expo   = {3'd0, top} + 8'd1;
    mant_n = mant;
    if (mant[MANT_W-1]) begin
      mant_n = {8'd0, mant[MANT_W-1:8]};
      expo   = expo + 8'd1;
    end
    code = any ? {expo, mant_n} : zero_code;
  end

endmodule
`default_nettype wire

/* test/compact_codec_checker.sv */
module compact_codec_checker
  import ctc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic                in_command,
  input  wire logic [CODE_W-1:0]   in_compact_in,
  input  wire logic [WORD_W-1:0]   in_target_in_w3,
  input  wire logic [WORD_W-1:0]   in_target_in_w2,
  input  wire logic [WORD_W-1:0]   in_target_in_w1,
  input  wire logic [WORD_W-1:0]   in_target_in_w0,
  input  wire logic                out_strobe,
  input  wire logic [WORD_W-1:0]   out_target_out_w3,
  input  wire logic [WORD_W-1:0]   out_target_out_w2,
  input  wire logic [WORD_W-1:0]   out_target_out_w1,
  input  wire logic [WORD_W-1:0]   out_target_out_w0,
  input  wire logic [CODE_W-1:0]   out_compact_out,
  input  wire logic [1:0]          out_status,
  input  wire logic                cfg_we,
  input  wire logic [CODE_W-1:0]   cfg_wdata,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [CODE_W-1:0] compact;
    ctc_status_t       status;
  } conversion_t;

  conversion_t       conversion_q[$];
  logic [CODE_W-1:0] zero_code = '0;

  function automatic conversion_t expand_code(logic [CODE_W-1:0] code);
    conversion_t       r;
    logic [MANT_W-1:0] mant;
    int                expo;
    int                pos;
    r = '0;
    mant = {1'b0, code[22:0]};
    expo = int'(code[31:24]);
    if (mant[23:16] == 8'h00) begin
      mant = mant << 8;
      expo = expo - 1;
    end
    for (int k = 0; k < 3; k++) begin
      pos = expo - 3 + k;
      if (pos >= 0 && pos < 32) r.target[pos*8 +: 8] = mant[k*8 +: 8];
    end
    if (code[23]) r.status = ST_SIGN;
    else if (expo < 0 || expo > 32) r.status = ST_EXP_OOR;
    else r.status = ST_OK;
    return r;
  endfunction

  function automatic conversion_t compress_target(logic [TGT_W-1:0] t);
    conversion_t       r;
    logic [MANT_W-1:0] mant;
    int                top;
    int                expo;
    int                pos;
    r = '0;
    r.status = ST_OK;
    top = -1;
    for (int p = 31; p >= 0; p--) begin
      if (top < 0 && t[p*8 +: 8] != 8'h00) top = p;
    end
    if (top < 0) begin
      r.compact = zero_code;
      return r;
    end
    expo = top + 1;
    mant = '0;
    for (int k = 0; k < 3; k++) begin
      pos = top - k;
      if (pos >= 0) mant[(2-k)*8 +: 8] = t[pos*8 +: 8];
    end
    if (mant[23]) begin
      mant = mant >> 8;
      expo = expo + 1;
    end
    r.compact = {expo[7:0], mant};
    return r;
  endfunction

  function automatic void check_field(string name, logic [TGT_W-1:0] want,
                                      logic [TGT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    conversion_t want;
    if (!rst_n) begin
      conversion_q.delete();
      zero_code = '0;
    end else begin
      if (out_strobe) begin
        if (conversion_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          fail_count++;
        end else begin
          want = conversion_q.pop_front();
          check_field("target_out_w3", want.target[255:192], out_target_out_w3);
          check_field("target_out_w2", want.target[191:128], out_target_out_w2);
          check_field("target_out_w1", want.target[127:64], out_target_out_w1);
          check_field("target_out_w0", want.target[63:0], out_target_out_w0);
          check_field("compact_out", want.compact, out_compact_out);
          check_field("status", want.status, out_status);
        end
      end
      if (start && !busy) begin
        if (in_command == CMD_COMPRESS)
          conversion_q.push_back(compress_target({in_target_in_w3, in_target_in_w2,
                                                  in_target_in_w1, in_target_in_w0}));
        else
          conversion_q.push_back(expand_code(in_compact_in));
      end
      if (cfg_we) zero_code = cfg_wdata;
    end
    pending = conversion_q.size();
  end

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctc_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam logic [TGT_W-1:0] ALL_ONES = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ctc_cmd_t          in_command = CMD_EXPAND;
  logic [CODE_W-1:0] in_compact_in = '0;
  logic [WORD_W-1:0] in_target_in_w3 = '0;
  logic [WORD_W-1:0] in_target_in_w2 = '0;
  logic [WORD_W-1:0] in_target_in_w1 = '0;
  logic [WORD_W-1:0] in_target_in_w0 = '0;
  logic              out_strobe;
  logic [WORD_W-1:0] out_target_out_w3;
  logic [WORD_W-1:0] out_target_out_w2;
  logic [WORD_W-1:0] out_target_out_w1;
  logic [WORD_W-1:0] out_target_out_w0;
  logic [CODE_W-1:0] out_compact_out;
  logic [1:0]        out_status;
  logic              cfg_we = 1'b0;
  logic [CODE_W-1:0] cfg_wdata = '0;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;

  compact_target_codec_unit uut (.*);
  compact_codec_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [TGT_W-1:0] random_wide();
    logic [TGT_W-1:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    logic [7:0]  expo;
    logic [22:0] mant;
    logic        sign;
    if ($urandom_range(0, 9) < 7) expo = 8'($urandom_range(0, 35));
    else expo = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2: mant = {7'h00, 16'($urandom)};
      3:       mant = '0;
      4:       mant = {15'h0000, 8'($urandom)};
      default: mant = 23'($urandom);
    endcase
    sign = ($urandom_range(0, 3) == 0);
    return {expo, sign, mant};
  endfunction

  function automatic logic [TGT_W-1:0] random_target();
    logic [TGT_W-1:0] t;
    int               lead;
    lead = $urandom_range(0, 32);
    t = random_wide() >> (lead * 8);
    // keep only a few bytes below the leading one
    if ($urandom_range(0, 4) == 0) t &= ~(ALL_ONES >> ((lead + $urandom_range(1, 4)) * 8));
    return t;
  endfunction

  task automatic drive_item(ctc_cmd_t cmd, logic [CODE_W-1:0] code, logic [TGT_W-1:0] t);
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_compact_in <= code;
    {in_target_in_w3, in_target_in_w2, in_target_in_w1, in_target_in_w0} <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic expand_item(logic [CODE_W-1:0] code);
    drive_item(CMD_EXPAND, code, random_wide());
  endtask

  task automatic compress_item(logic [TGT_W-1:0] t);
    drive_item(CMD_COMPRESS, $urandom, t);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_command <= ctc_cmd_t'($urandom_range(0, 1));
      in_compact_in <= $urandom;
      {in_target_in_w3, in_target_in_w2, in_target_in_w1, in_target_in_w0} <= random_wide();
    end
  endtask

  task automatic drain();
    do idle(1); while (pending != 0);
    idle(4);
  endtask

  task automatic write_zero_code(logic [CODE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= $urandom;
  endtask

  task automatic run_random(int count);
    int n;
    int burst;
    n = 0;
    while (n < count) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      for (int i = 0; i < burst && n < count; i++) begin
        if ($urandom_range(0, 1) == 0) expand_item(random_code());
        else compress_item(random_target());
        n++;
      end
      if ($urandom_range(0, 29) == 0) drain();
      else if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [CODE_W-1:0] codes[4];
    codes[0] = 32'hffff_ffff;
    codes[1] = 32'h0000_0000;
    codes[2] = $urandom;
    codes[3] = 32'h8000_0001;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // expand corners: shifted mantissa, small/large exponents, sign
    expand_item(32'h0000_0000);
    expand_item(32'h0000_0001);
    expand_item(32'h0100_3456);
    expand_item(32'h0112_3456);
    expand_item(32'h0212_3456);
    expand_item(32'h0312_3456);
    expand_item(32'h1d00_ffff);
    expand_item(32'h2012_3456);
    expand_item(32'h2100_3456);
    expand_item(32'h2112_3456);
    expand_item(32'h2212_3456);
    expand_item(32'hff7f_ffff);
    expand_item(32'h0492_3456);
    expand_item(32'hff80_0000);
    // compress corners: zero, full, tiny, renormalized mantissa
    compress_item('0);
    compress_item(ALL_ONES);
    compress_item(256'h1);
    compress_item(256'h80);
    compress_item(256'h8000);
    compress_item(256'h7f_ffff);
    compress_item({8'h80, 248'h0});
    compress_item({8'h01, 248'h0});
    compress_item(256'hffff << 208);
    compress_item(256'h1234_5678 << 100);

    foreach (codes[i]) begin
      drain();
      write_zero_code(codes[i]);
      compress_item('0);
      run_random(375);
    end
    drain();
    idle(8);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ctc_pkg.sv
rtl/ctc_expand.sv
rtl/ctc_compress.sv
rtl/compact_target_codec_unit.sv
test/compact_codec_checker.sv
test/testbench.sv
